// ===== hdl/ubd_pkg.sv =====
// ----------------------------------------------------------------------------
// ubd_pkg
// types, constants and helpers shared by the utf-8 byte stream decoder
// ----------------------------------------------------------------------------
package ubd_pkg;

   localparam logic [7:0] ASCII_TOP = 8'd127;

   localparam logic [31:0] OFFSET_LEN2 = 32'h0000_3080;
   localparam logic [31:0] OFFSET_LEN3 = 32'h000E_2080;
   localparam logic [31:0] OFFSET_LEN4 = 32'h03C8_2080;
   localparam logic [31:0] OFFSET_LEN5 = 32'hFA08_2080;
   localparam logic [31:0] OFFSET_LEN6 = 32'h8208_2080;

   // classified byte held in the queue
   typedef struct packed {
      logic [7:0] data;
      logic [2:0] trail;
   } entry_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   // number of trailing bytes announced by a lead byte
   function automatic logic [2:0] trail_count(input logic [7:0] b);
      logic [2:0] t;
      if (b <= ASCII_TOP) begin
         t = 3'd0;
      end else if (b < 8'hC0) begin
         t = 3'd0;
      end else if (b < 8'hE0) begin
         t = 3'd1;
      end else if (b < 8'hF0) begin
         t = 3'd2;
      end else if (b < 8'hF8) begin
         t = 3'd3;
      end else if (b < 8'hFC) begin
         t = 3'd4;
      end else begin
         t = 3'd5;
      end
      return t;
   endfunction

   // offset removed from the accumulator for a sequence of a given length
   function automatic logic [31:0] len_offset(input logic [2:0] len);
      logic [31:0] o;
      case (len)
         3'd2:    o = OFFSET_LEN2;
         3'd3:    o = OFFSET_LEN3;
         3'd4:    o = OFFSET_LEN4;
         3'd5:    o = OFFSET_LEN5;
         3'd6:    o = OFFSET_LEN6;
         default: o = 32'd0;
      endcase
      return o;
   endfunction

endpackage

// ===== hdl/utf8_byte_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// decodes a byte stream of utf-8 sequences of up to six bytes
// ----------------------------------------------------------------------------
// usage
//   req channel: one raw byte per word; rsp channel: one decoded character
//   per completed sequence, code point and sequence length
//   a front end classifies each byte and parks it in a two-entry queue,
//   a back end accumulates sequences into a registered result word
//   throughput: one byte per cycle while no completing byte waits on a stalled
//   rsp, set by the single shift-add step of the back end; bytes that complete
//   no character give no rsp word
//   a completing byte passes the queue head, then the result register, before
//   it shows on rsp; when rsp_tready is low the result register holds; bytes
//   that complete no character still drain, and req_tready drops once the next
//   completing byte and one more byte wait in the queue; no word is lost
//   reset clears the queue, the open sequence and the result valid
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] code_point, [34:32] seq_bytes
);
   import ubd_pkg::*;

   head_type head;
   logic     pop;

   ubd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .head       (head),
      .pop        (pop)
   );

   ubd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== hdl/ubd_front.sv =====
// ----------------------------------------------------------------------------
// ubd_front
// accepts bytes, classifies lead bytes and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module ubd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   output ubd_pkg::head_type head,
   input  logic              pop
);
   import ubd_pkg::*;

   entry_type  queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       take;
   entry_type  new_entry;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign take       = pop && (count_ff != 2'd0);

   assign new_entry.data  = req_tdata;
   assign new_entry.trail = trail_count(req_tdata);

   assign head.valid = (count_ff != 2'd0);
   assign head.entry = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !take) begin
         count_in = count_ff + 2'd1;
      end else if (take && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

// ===== hdl/ubd_back.sv =====
// ----------------------------------------------------------------------------
// ubd_back
// sequence accumulator and registered result word
// ----------------------------------------------------------------------------
module ubd_back (
   input  logic              clock,
   input  logic              reset,
   input  ubd_pkg::head_type head,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata
);
   import ubd_pkg::*;

   logic [31:0] acc_ff, acc_in;
   logic [2:0]  left_ff, left_in;
   logic [2:0]  len_ff, len_in;
   logic        valid_ff, valid_in;
   logic [31:0] code_ff, code_in;
   logic [2:0]  nbytes_ff, nbytes_in;
   logic [31:0] acc_shift;
   logic        emits;
   logic        can_out;

   assign acc_shift = {acc_ff[25:0], 6'b0} + {24'b0, head.entry.data};
   assign emits     = (left_ff == 3'd0) ? (head.entry.trail == 3'd0) : (left_ff == 3'd1);
   assign can_out   = !valid_ff || rsp_tready;
   assign pop       = head.valid && (!emits || can_out);

   always_comb begin
      acc_in    = acc_ff;
      left_in   = left_ff;
      len_in    = len_ff;
      code_in   = code_ff;
      nbytes_in = nbytes_ff;
      valid_in  = rsp_tready ? 1'b0 : valid_ff;
      if (pop) begin
         if (left_ff == 3'd0) begin
            if (head.entry.trail == 3'd0) begin
               code_in   = {24'b0, head.entry.data};
               nbytes_in = 3'd1;
               valid_in  = 1'b1;
            end else begin
               acc_in  = {24'b0, head.entry.data};
               left_in = head.entry.trail;
               len_in  = head.entry.trail + 3'd1;
            end
         end else begin
            left_in = left_ff - 3'd1;
            if (left_ff == 3'd1) begin
               code_in   = acc_shift - len_offset(len_ff);
               nbytes_in = len_ff;
               valid_in  = 1'b1;
               acc_in    = 32'd0;
               len_in    = 3'd0;
            end else begin
               acc_in = acc_shift;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= 32'd0;
         left_ff  <= 3'd0;
         len_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         left_ff  <= left_in;
         len_ff   <= len_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff   <= code_in;
      nbytes_ff <= nbytes_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'b0, nbytes_ff, code_ff};

endmodule

// ===== hdl/ubd_checker.sv =====
// ----------------------------------------------------------------------------
// ubd_checker
// port-level checks on the decoder result channel
// ----------------------------------------------------------------------------
module ubd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // stalled word stays
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // sequence length one to six
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[34:32] != 3'd0 && rsp_tdata[34:32] != 3'd7)
      else $error("rsp sequence length out of range");

   // single-byte words carry only the byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34:32] == 3'd1 |-> rsp_tdata[31:8] == 24'd0)
      else $error("single byte word wider than a byte");

   // an accepted byte never overruns: ready low only while results back up
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no pending result");

endmodule

bind utf8_byte_stream_decoder ubd_checker u_ubd_checker (.*);
